>>> design/sbmq_pkg.sv
// ---------------------------------------------------------------------------
// sbmq_pkg
// Shared types and codes for the shared buffer multi-queue unit.
// ---------------------------------------------------------------------------
package sbmq_pkg;

    localparam int DATA_W   = 32;
    localparam int QID_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC
    } sbmq_state_t;

endpackage

>>> design/sbmq_req_if.sv
// ---------------------------------------------------------------------------
// sbmq_req_if
// Request channel: operation, queue number and push word.
// ---------------------------------------------------------------------------
interface sbmq_req_if
    import sbmq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [QID_W-1:0]         queue_id;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output op, output queue_id, output push_value,
                    input ready);
    modport sink   (input valid, input op, input queue_id, input push_value,
                    output ready);
endinterface

>>> design/sbmq_rsp_if.sv
// ---------------------------------------------------------------------------
// sbmq_rsp_if
// Response channel: status code and popped word.
// ---------------------------------------------------------------------------
interface sbmq_rsp_if
    import sbmq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] pop_value;

    modport source (output valid, output status, output pop_value, input ready);
    modport sink   (input valid, input status, input pop_value, output ready);
endinterface

>>> design/sbmq_ram.sv
// ---------------------------------------------------------------------------
// sbmq_ram
// Single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module sbmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read data holds until the next read access.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

>>> design/shared_buffer_multi_queue_unit.sv
// ---------------------------------------------------------------------------
// shared_buffer_multi_queue_unit
// Several FIFO queues chained through one shared slot store with a free list.
// ---------------------------------------------------------------------------
// Response: a request is held through the execute state, and its result is then
//   registered in the output register; execute waits while a result blocks it.
// Requests: one at a time, as req.ready is high only while idle; this is set by
//   the single-port link RAM (read in the accept cycle, write-back in execute).
// Reset: queues empty, free list holds every slot in order. After reset the
//   link RAM is chained by a pass over every slot; req.ready stays low then.
// ---------------------------------------------------------------------------
module shared_buffer_multi_queue_unit
    import sbmq_pkg::*;
#(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    sbmq_req_if.sink    req,
    sbmq_rsp_if.source  rsp
);

    // Pointer width holds every slot index plus the null code SLOTS.
    localparam int PW  = $clog2(SLOTS + 1);
    localparam int AW  = $clog2(SLOTS);
    // Only the queues that the queue number field can reach get registers.
    localparam int QN  = (QUEUES < (1 << QID_W)) ? QUEUES : (1 << QID_W);
    localparam int QIW = (QN > 1) ? $clog2(QN) : 1;
    localparam logic [PW-1:0] NIL       = PW'(SLOTS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    sbmq_state_t state_reg, state_next;

    logic [AW-1:0]  init_cnt_reg;
    logic [PW-1:0]  free_head_reg;
    logic [PW-1:0]  head_reg [QN];
    logic [PW-1:0]  tail_reg [QN];

    // Request held across the execute cycle.
    logic           op_reg;
    logic [QIW-1:0] qidx_reg;
    logic           qok_reg;
    logic [PW-1:0]  slot_reg;
    logic           slot_ok_reg;

    // Output register decouples the result from the request side.
    logic                     rsp_valid_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic signed [DATA_W-1:0] pop_value_reg;

    logic           accept;
    logic           exec_adv;
    logic [QIW-1:0] qidx;
    logic           q_ok;
    logic [PW-1:0]  head_sel;
    logic [PW-1:0]  slot_sel;
    logic [PW-1:0]  head_q;
    logic [PW-1:0]  tail_q;
    logic           push_ok;
    logic           pop_ok;

    logic           link_en;
    logic           link_we;
    logic [AW-1:0]  link_addr;
    logic [PW-1:0]  link_wdata;
    logic [PW-1:0]  link_rdata;

    logic           data_en;
    logic           data_we;
    logic [DATA_W-1:0] data_rdata;

    sbmq_ram #(
        .WIDTH (PW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .en    (link_en),
        .we    (link_we),
        .addr  (link_addr),
        .wdata (link_wdata),
        .rdata (link_rdata)
    );

    sbmq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .clk   (clk),
        .en    (data_en),
        .we    (data_we),
        .addr  (slot_sel[AW-1:0]),
        .wdata (req.push_value),
        .rdata (data_rdata)
    );

    // Decode the incoming request. Out-of-range queue numbers touch nothing.
    always_comb
    begin
        qidx     = req.queue_id[QIW-1:0];
        q_ok     = ({{(32-QID_W){1'b0}}, req.queue_id} < 32'(QUEUES));
        head_sel = q_ok ? head_reg[qidx] : NIL;
        slot_sel = (req.op == OP_PUSH) ? free_head_reg : head_sel;
        head_q   = qok_reg ? head_reg[qidx_reg] : NIL;
        tail_q   = qok_reg ? tail_reg[qidx_reg] : NIL;
        push_ok  = (op_reg == OP_PUSH) && qok_reg && slot_ok_reg;
        pop_ok   = (op_reg == OP_POP) && qok_reg && slot_ok_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (init_cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Handshake and RAM controls.
    always_comb
    begin
        req.ready  = (state_reg == ST_IDLE);
        accept     = req.ready && req.valid;
        // Execute only when the output register is free or being drained.
        exec_adv   = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp.ready);

        // Store the push word straight away; the slot is already reserved.
        data_en    = accept && (req.op == OP_POP || (q_ok && slot_sel < NIL));
        data_we    = (req.op == OP_PUSH);

        link_en    = 1'b0;
        link_we    = 1'b0;
        link_addr  = slot_sel[AW-1:0];
        link_wdata = free_head_reg;
        case (state_reg)
            ST_INIT:
            begin
                // Chain slot i to slot i+1; the last slot lands on null.
                link_en    = 1'b1;
                link_we    = 1'b1;
                link_addr  = init_cnt_reg;
                link_wdata = PW'(init_cnt_reg) + PW'(1);
            end
            ST_IDLE:
            begin
                // Fetch the next link of the free head (push) or queue head (pop).
                link_en = accept;
            end
            ST_EXEC:
            begin
                if (push_ok)
                begin
                    // Append behind the old tail when the queue is not empty.
                    link_en    = exec_adv && (head_q < NIL) && (tail_q < NIL);
                    link_we    = 1'b1;
                    link_addr  = tail_q[AW-1:0];
                    link_wdata = slot_reg;
                end
                else if (pop_ok)
                begin
                    // Return the slot to the front of the free list.
                    link_en    = exec_adv;
                    link_we    = 1'b1;
                    link_addr  = slot_reg[AW-1:0];
                    link_wdata = free_head_reg;
                end
            end
            default:
            begin
                link_en = 1'b0;
            end
        endcase

        rsp.valid     = rsp_valid_reg;
        rsp.status    = status_reg;
        rsp.pop_value = pop_value_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_cnt_reg  <= '0;
            free_head_reg <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < QN; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_INIT)
            begin
                init_cnt_reg <= init_cnt_reg + AW'(1);
            end

            if (exec_adv)
            begin
                rsp_valid_reg <= 1'b1;
                if (push_ok)
                begin
                    free_head_reg <= link_rdata;
                    if (!(head_q < NIL))
                    begin
                        head_reg[qidx_reg] <= slot_reg;
                    end
                    tail_reg[qidx_reg] <= slot_reg;
                end
                else if (pop_ok)
                begin
                    // The tail slot's link is never written on push; the
                    // chain ends there, so the head goes to null.
                    head_reg[qidx_reg] <= (slot_reg == tail_q) ? NIL : link_rdata;
                    free_head_reg      <= slot_reg;
                end
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= req.op;
            qidx_reg    <= qidx;
            qok_reg     <= q_ok;
            slot_reg    <= slot_sel;
            slot_ok_reg <= (slot_sel < NIL);
        end
        if (exec_adv)
        begin
            if (op_reg == OP_PUSH)
            begin
                status_reg    <= push_ok ? STATUS_OK : STATUS_OVERFLOW;
                pop_value_reg <= '0;
            end
            else
            begin
                status_reg    <= pop_ok ? STATUS_OK : STATUS_UNDERFLOW;
                pop_value_reg <= pop_ok ? data_rdata : '1;
            end
        end
    end

    // A transfer always moves the block into its execute cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("request transfer did not enter execute");

    // The free head is a slot index or null, never beyond.
    a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= NIL)
        else $error("free head out of range");

    // Hold the execute cycle while an untaken result blocks the output.
    a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EXEC) && rsp_valid_reg && !rsp.ready)
        |=> ((state_reg == ST_EXEC) && $stable(status_reg)))
        else $error("execute advanced over a pending result");

    // The link RAM is only read while idle.
    a_idle_no_link_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && link_en) |-> !link_we)
        else $error("link write while idle");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Runs push and pop requests through the shared buffer multi-queue unit.
// A shadow of the slot store, link chain, queue heads and tails and the free
// list works out each response, which is then compared field by field with
// what the unit returns. The request side works in bursts with gaps and the
// response side stalls in modes of its own that change from time to time.
// ---------------------------------------------------------------------------
module testbench;

    import sbmq_pkg::*;

    localparam int SLOT_COUNT   = 16;
    localparam int QUEUE_COUNT  = 4;
    localparam int LINK_W       = $clog2(SLOT_COUNT + 1);
    localparam int RANDOM_ITEMS = 1600;

    typedef logic [LINK_W-1:0] link_t;
    localparam link_t NULL_LINK = link_t'(SLOT_COUNT);

    // One pending request; drain_first holds it back until every earlier
    // response has come home.
    typedef struct {
        logic               op;
        logic [QID_W-1:0]   queue_id;
        logic [DATA_W-1:0]  push_value;
        bit                 drain_first;
    } queue_request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   pop_value;
    } queue_answer_t;

    // Response-side stall behaviour, changed from time to time.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_PATTERN,
        RX_COIN,
        RX_SLUGGISH
    } rx_mode_t;

    logic clk;
    logic rst_n;

    sbmq_req_if req_bus ();
    sbmq_rsp_if rsp_bus ();

    shared_buffer_multi_queue_unit #(
        .SLOTS  (SLOT_COUNT),
        .QUEUES (QUEUE_COUNT)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // -----------------------------------------------------------------------
    // Shadow of the queue store
    // -----------------------------------------------------------------------
    logic [DATA_W-1:0] slot_word [SLOT_COUNT];
    link_t             slot_next [SLOT_COUNT];
    link_t             q_head    [QUEUE_COUNT];
    link_t             q_tail    [QUEUE_COUNT];
    link_t             free_slot;

    queue_request_t request_backlog [$];
    queue_answer_t  answer_backlog  [$];

    bit req_taken;
    int answers_seen;
    int error_count;

    // Chain every slot onto the free list and empty all queues.
    function automatic void clear_queue_store();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_word[i] = '0;
            slot_next[i] = (i == SLOT_COUNT - 1) ? NULL_LINK : link_t'(i + 1);
        end
        for (int i = 0; i < QUEUE_COUNT; i++)
        begin
            q_head[i] = NULL_LINK;
            q_tail[i] = NULL_LINK;
        end
        free_slot = '0;
    endfunction

    // Apply one operation to the shadow store and return the response that
    // the unit must give for it. Any link at or above SLOT_COUNT counts as
    // null. The queue number guard only bites for a narrower QUEUE_COUNT.
    function automatic queue_answer_t apply_queue_op(input logic op,
                                                     input logic [QID_W-1:0] qid,
                                                     input logic [DATA_W-1:0] word);
        queue_answer_t ans;
        link_t         slot;
        if (op == OP_PUSH)
        begin
            ans.pop_value = '0;
            if (int'(qid) >= QUEUE_COUNT || free_slot >= SLOT_COUNT)
                ans.status = STATUS_OVERFLOW;
            else
            begin
                slot      = free_slot;
                free_slot = slot_next[slot];
                // An empty queue starts its chain afresh, whatever its stale
                // tail still points at.
                if (q_head[qid] >= SLOT_COUNT)
                    q_head[qid] = slot;
                else if (q_tail[qid] < SLOT_COUNT)
                    slot_next[q_tail[qid]] = slot;
                slot_next[slot] = NULL_LINK;
                q_tail[qid]     = slot;
                slot_word[slot] = word;
                ans.status      = STATUS_OK;
            end
        end
        else
        begin
            if (int'(qid) >= QUEUE_COUNT || q_head[qid] >= SLOT_COUNT)
            begin
                ans.status    = STATUS_UNDERFLOW;
                ans.pop_value = '1;
            end
            else
            begin
                slot            = q_head[qid];
                q_head[qid]     = slot_next[slot];
                slot_next[slot] = free_slot;
                free_slot       = slot;
                ans.pop_value   = slot_word[slot];
                ans.status      = STATUS_OK;
            end
        end
        return ans;
    endfunction

    function automatic void add_request(input logic op, input int qid,
                                        input logic [DATA_W-1:0] word,
                                        input bit drain);
        queue_request_t item;
        item.op          = op;
        item.queue_id    = QID_W'(qid);
        item.push_value  = word;
        item.drain_first = drain;
        request_backlog.push_back(item);
    endfunction

    // -----------------------------------------------------------------------
    // Clock, reset and time limit
    // -----------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        // Hold every input at a known value until the drivers take over.
        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.op         = OP_PUSH;
        req_bus.queue_id   = '0;
        req_bus.push_value = '0;
        rsp_bus.ready      = 1'b0;
        clear_queue_store();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // End the run as failed if it has not finished well before this limit.
    initial
    begin
        #6ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Request driver: bursts of random length with random gaps. Hold valid
    // and payload steady until the transfer completes.
    // -----------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(negedge clk)
    begin : drive_requests
        bit             offer;
        queue_request_t nxt;
        if (rst_n)
        begin
            offer = 1'b0;
            if (req_bus.valid && req_taken)
            begin
                request_backlog.delete(0);
                if (burst_left > 0)
                    burst_left--;
            end
            if (req_bus.valid && !req_taken)
                offer = 1'b1;
            else if (request_backlog.size() != 0 &&
                     !(request_backlog[0].drain_first && answer_backlog.size() != 0))
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (gap_left > 0)
                    gap_left--;
                else
                    offer = 1'b1;
            end
            if (offer)
            begin
                nxt = request_backlog[0];
                req_bus.op         <= nxt.op;
                req_bus.queue_id   <= nxt.queue_id;
                req_bus.push_value <= nxt.push_value;
            end
            req_bus.valid <= offer;
        end
    end

    // -----------------------------------------------------------------------
    // Response ready: change stall mode every so often, and once hold off
    // for a long stretch so the unit backs up into its request side.
    // -----------------------------------------------------------------------
    rx_mode_t rx_mode;
    int       rx_mode_left;
    int       rx_cycle;
    int       hold_off_left;
    bit       hold_off_done;

    always @(negedge clk)
    begin : drive_ready
        bit rdy;
        if (rst_n)
        begin
            rx_cycle++;
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(64, 256);
            end
            else
                rx_mode_left--;
            if (!hold_off_done && answers_seen >= 300)
            begin
                hold_off_done = 1'b1;
                hold_off_left = 150;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                rdy = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS:   rdy = 1'b1;
                    RX_PATTERN:  rdy = (rx_cycle % 5) != 2 && (rx_cycle % 7) != 0;
                    RX_COIN:     rdy = $urandom_range(0, 1);
                    default:     rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            rsp_bus.ready <= rdy;
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: predict on each request transfer, then check each response
    // transfer against the oldest prediction.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : check_answers
        queue_answer_t want;
        req_taken <= req_bus.valid && req_bus.ready;
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
                answer_backlog.push_back(apply_queue_op(req_bus.op, req_bus.queue_id,
                                                        req_bus.push_value));
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                answers_seen <= answers_seen + 1;
                if (answer_backlog.size() == 0)
                begin
                    $error("unexpected response: status %0d pop_value %08h",
                           rsp_bus.status, rsp_bus.pop_value);
                    error_count++;
                end
                else
                begin
                    want = answer_backlog.pop_front();
                    if (rsp_bus.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                        error_count++;
                    end
                    if (rsp_bus.pop_value !== want.pop_value)
                    begin
                        $error("pop_value: expected %08h, got %08h",
                               want.pop_value, rsp_bus.pop_value);
                        error_count++;
                    end
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run
    // -----------------------------------------------------------------------
    initial
    begin : stimulus
        logic [DATA_W-1:0] corner [4];
        int                made;
        int                seg_len;
        int                push_pct;
        int                focus;
        int                qid;
        logic [DATA_W-1:0] word;

        corner[0] = 32'h7FFF_FFFF;
        corner[1] = 32'h8000_0000;
        corner[2] = 32'hFFFF_FFFF;
        corner[3] = 32'h0000_0000;

        // Pop from empty queues straight after reset.
        add_request(OP_POP, 0, 32'h1234_5678, 1'b0);
        add_request(OP_POP, QUEUE_COUNT - 1, 32'hFFFF_FFFF, 1'b0);
        // Push both signed extremes, pop them back, then underflow.
        add_request(OP_PUSH, 0, corner[0], 1'b0);
        add_request(OP_PUSH, 0, corner[1], 1'b0);
        add_request(OP_POP, 0, 32'h0, 1'b0);
        add_request(OP_POP, 0, 32'h0, 1'b0);
        add_request(OP_POP, 0, 32'h0, 1'b0);
        // Queue 0 now has a stale tail; restart its chain.
        add_request(OP_PUSH, 0, corner[2], 1'b0);
        add_request(OP_PUSH, 1, corner[3], 1'b0);
        // Use up every free slot across all queues, then overflow once.
        for (int i = 0; i < SLOT_COUNT - 1; i++)
            add_request(OP_PUSH, i % QUEUE_COUNT,
                        (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555, 1'b0);

        // Random part in segments: push-heavy segments fill the store and
        // overflow, pop-heavy ones drain it and underflow. At least half the items
        // address one focus queue so that long chains build up.
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            seg_len = $urandom_range(16, 64);
            case ($urandom_range(0, 2))
                0:       push_pct = 15;
                1:       push_pct = 50;
                default: push_pct = 85;
            endcase
            focus = $urandom_range(0, QUEUE_COUNT - 1);
            for (int k = 0; k < seg_len && made < RANDOM_ITEMS; k++)
            begin
                qid  = $urandom_range(0, 1) ? focus : $urandom_range(0, QUEUE_COUNT - 1);
                word = ($urandom_range(0, 19) == 0) ? corner[$urandom_range(0, 3)]
                                                    : $urandom;
                add_request(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP,
                            qid, word, (made % 400) == 0);
                made++;
            end
        end

        wait (rst_n === 1'b1);
        while (request_backlog.size() != 0 || answer_backlog.size() != 0)
            @(posedge clk);
        // Catch any stray response after the last expected one.
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
